// ===== rtl/pna_pkg.sv =====
// Shared types, constants and codes for the pooled node allocator.
`timescale 1ns / 1ps

package pna_pkg;

    localparam int POOL_COUNT_DEF       = 64;
    localparam int NODES_PER_POOL_DEF   = 4096;
    localparam int FREE_STACK_DEPTH_DEF = 1024;

    localparam int POOL_W   = 6;
    localparam int OFFSET_W = 12;
    localparam int ENTRY_W  = POOL_W + OFFSET_W;
    localparam int STATUS_W = 2;
    localparam int PPS_W    = 4;
    localparam int ROT_W    = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [PPS_W-1:0] PPS_RESET = 4'd1;
    localparam logic [PPS_W-1:0] PPS_MAX   = 4'd8;

    localparam logic [APB_AW-1:0] ADDR_POOLS_PER_SET = 3'd0;

    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOC      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREED      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd3;

    typedef struct packed {
        logic                opcode;
        logic [POOL_W-1:0]   free_pool;
        logic [OFFSET_W-1:0] free_offset;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POOL_W-1:0]   grant_pool;
        logic [OFFSET_W-1:0] grant_offset;
        logic                reused;
    } t_result;

    typedef struct packed {
        logic load;
        logic rd2;
        logic commit_free;
        logic commit_pop;
        logic commit_bump1;
        logic commit_bump2;
        logic report_full;
        logic report_exh;
    } t_cmd;

    typedef struct packed {
        logic op_free;
        logic stack_empty;
        logic stack_full;
        logic fill1_full;
        logic fill2_full;
        logic set_left;
    } t_sts;

endpackage

// ===== rtl/pna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pna_ctrl.sv =====
// Request sequencer: accept, evaluate, optional second pool lookup.
`timescale 1ns / 1ps

module pna_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  pna_pkg::t_sts i_sts,
    output pna_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    import pna_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_EVAL2 = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_cmd       cmd;

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        cmd.load = i_accept;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (i_sts.op_free) begin
                    if (i_sts.stack_full) begin
                        cmd.report_full = 1'b1;
                    end else begin
                        cmd.commit_free = 1'b1;
                    end
                end else if (!i_sts.stack_empty) begin
                    cmd.commit_pop = 1'b1;
                end else if (!i_sts.fill1_full) begin
                    cmd.commit_bump1 = 1'b1;
                end else if (!i_sts.set_left) begin
                    cmd.report_exh = 1'b1;
                end else begin
                    cmd.rd2 = 1'b1;
                    n_state = S_EVAL2;
                end
            end
            S_EVAL2: begin
                n_state = S_IDLE;
                if (i_sts.fill2_full) begin
                    cmd.report_exh = 1'b1;
                end else begin
                    cmd.commit_bump2 = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/pna_dp.sv =====
// Datapath: free stack, pool fill counters, set base, rotation, result register.
`timescale 1ns / 1ps

module pna_dp #(
    parameter int POOL_COUNT       = pna_pkg::POOL_COUNT_DEF,
    parameter int NODES_PER_POOL   = pna_pkg::NODES_PER_POOL_DEF,
    parameter int FREE_STACK_DEPTH = pna_pkg::FREE_STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pna_pkg::t_request            i_req,
    input  logic [pna_pkg::PPS_W-1:0]    i_pps,
    input  pna_pkg::t_cmd                i_cmd,
    output pna_pkg::t_sts                o_sts,
    output logic                         o_done,
    output pna_pkg::t_result             o_rsp
);

    import pna_pkg::*;

    localparam int PAW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int BW  = $clog2(POOL_COUNT + 1);
    localparam int SW  = BW + 4;
    localparam int FW  = $clog2(NODES_PER_POOL + 1);
    localparam int SAW = (FREE_STACK_DEPTH > 1) ? $clog2(FREE_STACK_DEPTH) : 1;
    localparam int DW  = $clog2(FREE_STACK_DEPTH + 1);

    localparam logic [SW-1:0] POOL_LIM  = SW'(POOL_COUNT);
    localparam logic [FW-1:0] NODE_LIM  = FW'(NODES_PER_POOL);
    localparam logic [DW-1:0] DEPTH_LIM = DW'(FREE_STACK_DEPTH);

    // architectural state
    logic [DW-1:0]         r_depth;
    logic [BW-1:0]         r_base;
    logic [ROT_W-1:0]      r_rot;
    logic [POOL_COUNT-1:0] r_vld;

    // per-request working registers
    logic                  r_op;
    logic [POOL_W-1:0]     r_fpool;
    logic [OFFSET_W-1:0]   r_foff;
    logic [PPS_W-1:0]      r_n;
    logic [ROT_W-1:0]      r_rote;
    logic [SW-1:0]         r_p1;
    logic [SW-1:0]         r_p2;
    logic [SW-1:0]         r_nb;
    logic                  r_oob1;
    logic                  r_oob2;
    logic                  r_set_left;
    logic                  r_fvld;

    logic                  r_done;
    t_result               r_rsp;
    t_result               n_rsp;

    logic [PPS_W-1:0]      set_n;
    logic [ROT_W-1:0]      rot_e;
    logic [SW-1:0]         p1;
    logic [SW-1:0]         nb;
    logic [SW-1:0]         p2;
    logic [PPS_W-1:0]      rot_inc;
    logic [ROT_W-1:0]      rot_next;

    logic [PAW-1:0]        fill_raddr;
    logic [PAW-1:0]        fill_waddr;
    logic                  fill_re;
    logic                  fill_we;
    logic [FW-1:0]         fill_rdata;
    logic [FW-1:0]         fill_val;
    logic                  fill_ge;

    logic [ENTRY_W-1:0]    stk_rdata;
    logic                  rsp_en;

    always_comb begin
        if (i_pps == '0) begin
            set_n = PPS_RESET;
        end else if (i_pps > PPS_MAX) begin
            set_n = PPS_MAX;
        end else begin
            set_n = i_pps;
        end
        rot_e = ({1'b0, r_rot} < set_n) ? r_rot : '0;
        p1    = SW'(r_base) + SW'(rot_e);
        nb    = SW'(r_base) + SW'(set_n);
        p2    = nb + SW'(rot_e);
    end

    assign rot_inc  = PPS_W'(r_rote) + PPS_W'(1);
    assign rot_next = (rot_inc >= r_n) ? '0 : ROT_W'(rot_inc);

    assign fill_re    = i_cmd.load | i_cmd.rd2;
    assign fill_raddr = i_cmd.load ? PAW'(p1) : PAW'(r_p2);
    assign fill_we    = i_cmd.commit_bump1 | i_cmd.commit_bump2;
    assign fill_waddr = i_cmd.commit_bump2 ? PAW'(r_p2) : PAW'(r_p1);
    assign fill_val   = r_fvld ? fill_rdata : '0;
    assign fill_ge    = (fill_val >= NODE_LIM);

    pna_ram #(
        .WIDTH (FW),
        .DEPTH (POOL_COUNT)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_val + FW'(1)),
        .i_re    (fill_re),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    pna_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FREE_STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit_free),
        .i_waddr (SAW'(r_depth)),
        .i_wdata ({r_fpool, r_foff}),
        .i_re    (i_cmd.load),
        .i_raddr (SAW'(r_depth - DW'(1))),
        .o_rdata (stk_rdata)
    );

    assign rsp_en = i_cmd.commit_free | i_cmd.commit_pop | i_cmd.commit_bump1
                  | i_cmd.commit_bump2 | i_cmd.report_full | i_cmd.report_exh;

    always_comb begin
        n_rsp = '0;
        if (i_cmd.commit_free) begin
            n_rsp.status = ST_FREED;
        end else if (i_cmd.report_full) begin
            n_rsp.status = ST_STACK_FULL;
        end else if (i_cmd.report_exh) begin
            n_rsp.status = ST_EXHAUSTED;
        end else if (i_cmd.commit_pop) begin
            n_rsp.status       = ST_ALLOC;
            n_rsp.grant_pool   = stk_rdata[ENTRY_W-1:OFFSET_W];
            n_rsp.grant_offset = stk_rdata[OFFSET_W-1:0];
            n_rsp.reused       = 1'b1;
        end else if (i_cmd.commit_bump2) begin
            n_rsp.status       = ST_ALLOC;
            n_rsp.grant_pool   = POOL_W'(r_p2);
            n_rsp.grant_offset = OFFSET_W'(fill_val);
        end else begin
            n_rsp.status       = ST_ALLOC;
            n_rsp.grant_pool   = POOL_W'(r_p1);
            n_rsp.grant_offset = OFFSET_W'(fill_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_base  <= '0;
            r_rot   <= '0;
            r_vld   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= rsp_en;
            if (i_cmd.commit_free) begin
                r_depth <= r_depth + DW'(1);
            end
            if (i_cmd.commit_pop) begin
                r_depth <= r_depth - DW'(1);
            end
            if (fill_we) begin
                r_vld[fill_waddr] <= 1'b1;
                r_rot             <= rot_next;
            end
            if (i_cmd.commit_bump2) begin
                r_base <= BW'(r_nb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_req.opcode;
            r_fpool    <= i_req.free_pool;
            r_foff     <= i_req.free_offset;
            r_n        <= set_n;
            r_rote     <= rot_e;
            r_p1       <= p1;
            r_p2       <= p2;
            r_nb       <= nb;
            r_oob1     <= (p1 >= POOL_LIM);
            r_oob2     <= (p2 >= POOL_LIM);
            r_set_left <= ((nb + SW'(set_n)) <= POOL_LIM);
        end
        if (fill_re) begin
            r_fvld <= r_vld[fill_raddr];
        end
        if (rsp_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.op_free     = (r_op == OPC_FREE);
    assign o_sts.stack_empty = (r_depth == '0);
    assign o_sts.stack_full  = (r_depth >= DEPTH_LIM);
    assign o_sts.fill1_full  = r_oob1 | fill_ge;
    assign o_sts.fill2_full  = r_oob2 | fill_ge;
    assign o_sts.set_left    = r_set_left;

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== rtl/pooled_node_allocator.sv =====
// Top level of the pooled node allocator: APB register, sequencer and datapath.
// Sequencing: the result strobe is registered from the evaluate state, or from a
//   second evaluate state when the chosen pool is full and the next set is looked up.
// Requests: a new request is taken only while busy is low, so each one is finished
//   before the next is accepted; busy is high while a request is in work.
// Reset: synchronous, active low; fill counts clear at once through per-pool valid
//   bits, the free stack starts empty, pools_per_set returns to 1. Results cannot stall.
`timescale 1ns / 1ps

module pooled_node_allocator #(
    parameter int POOL_COUNT       = pna_pkg::POOL_COUNT_DEF,
    parameter int NODES_PER_POOL   = pna_pkg::NODES_PER_POOL_DEF,
    parameter int FREE_STACK_DEPTH = pna_pkg::FREE_STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pna_pkg::t_request            i_req,
    output logic                         o_done,
    output pna_pkg::t_result             o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pna_pkg::APB_AW-1:0]   paddr,
    input  logic [pna_pkg::APB_DW-1:0]   pwdata,
    output logic [pna_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import pna_pkg::*;

    logic [PPS_W-1:0] r_pps;
    logic             reg_sel;
    logic             accept;
    t_cmd             cmd;
    t_sts             sts;

    assign reg_sel = (paddr[APB_AW-1:2] == ADDR_POOLS_PER_SET[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pps <= PPS_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_pps <= pwdata[PPS_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DW'(r_pps) : '0;
    assign pready = 1'b1;

    assign accept = start & ~busy;

    pna_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pna_dp #(
        .POOL_COUNT       (POOL_COUNT),
        .NODES_PER_POOL   (NODES_PER_POOL),
        .FREE_STACK_DEPTH (FREE_STACK_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pps   (r_pps),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== rtl/pna_checker.sv =====
// Port-level checks for the pooled node allocator, bound to the top level.
`timescale 1ns / 1ps

module pna_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input pna_pkg::t_result o_rsp
);

    import pna_pkg::*;

    // an accepted beat keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("request finished without a result beat");

    a_reused_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.reused |-> o_rsp.status == ST_ALLOC)
        else $error("reused flag on a non-allocation result");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status == ST_FREED || o_rsp.status == ST_EXHAUSTED
                   || o_rsp.status == ST_STACK_FULL)
        |-> o_rsp.grant_pool == '0 && o_rsp.grant_offset == '0 && !o_rsp.reused)
        else $error("non-allocation result carries an address");

endmodule

bind pooled_node_allocator pna_checker u_pna_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
